// ===== rtl/core/chacha20_ctr_byte_xor_core_defines.svh =====
// assertion macros shared by the core
`ifndef CHACHA20_CTR_BYTE_XOR_CORE_DEFINES_SVH
`define CHACHA20_CTR_BYTE_XOR_CORE_DEFINES_SVH
// implication checked every clock outside reset
`define CC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// implication whose consequent is checked in the cycle after the antecedent
`define CC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== rtl/core/cc20_pkg.sv =====
package cc20_pkg;
  localparam logic [31:0] SIGMA0 = 32'h61707865;
  localparam logic [31:0] SIGMA1 = 32'h3320646e;
  localparam logic [31:0] SIGMA2 = 32'h79622d32;
  localparam logic [31:0] SIGMA3 = 32'h6b206574;
  localparam logic [31:0] LEN_MASK = 32'hA5A5A5A5;

  localparam logic [2:0] REG_KEY01 = 3'd0;
  localparam logic [2:0] REG_KEY23 = 3'd1;
  localparam logic [2:0] REG_KEY45 = 3'd2;
  localparam logic [2:0] REG_KEY67 = 3'd3;
  localparam logic [2:0] REG_SEED  = 3'd4;
  localparam logic [2:0] REG_LEN   = 3'd5;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FINAL
  } gen_state_t;

  // front to back queue entry
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       new_block;
    logic [5:0] pos;
  } cc20_item_t;

  // block request from back part to generator
  typedef struct packed {
    logic        start;
    logic [31:0] counter;
  } cc20_req_t;

  function automatic logic [31:0] rotl32(input logic [31:0] v, input int n);
    rotl32 = (v << n) | (v >> (32 - n));
  endfunction

  // one quarter round on four words
  function automatic logic [127:0] qround(input logic [31:0] a, input logic [31:0] b,
                                         input logic [31:0] c, input logic [31:0] d);
    logic [31:0] a1, b1, c1, d1;
    a1 = a + b;   d1 = rotl32(d ^ a1, 16);
    c1 = c + d1;  b1 = rotl32(b ^ c1, 12);
    a1 = a1 + b1; d1 = rotl32(d1 ^ a1, 8);
    c1 = c1 + d1; b1 = rotl32(b1 ^ c1, 7);
    qround = {d1, c1, b1, a1};
  endfunction
endpackage

// ===== rtl/core/cc20_front.sv =====
module cc20_front
  import cc20_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data,
  input  logic [31:0] msg_len,
  output logic        q_valid,
  input  logic        q_ready,
  output cc20_item_t  q_item
);
  localparam int QD = 2;

  cc20_item_t        q_mem [QD];
  logic              wp_r, rp_r;
  logic [1:0]        cnt_r;
  logic [5:0]        pos_r;
  logic [31:0]       done_r;
  logic              push, pop, last;
  cc20_item_t        item;

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign pop      = q_valid && q_ready;
  assign q_item   = q_mem[rp_r];

  // classify: position, block start, last byte
  always_comb begin
    last           = ((done_r + 32'd1) == msg_len);
    item.data      = in_data;
    item.last      = last;
    item.new_block = (pos_r == 6'd0);
    item.pos       = pos_r;
  end

  always_ff @(posedge clk) begin
    if (push) q_mem[wp_r] <= item;
  end

  // queue pointers and byte counts
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
      pos_r <= 6'd0; done_r <= 32'd0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
        if (last) begin
          pos_r <= 6'd0; done_r <= 32'd0;
        end else begin
          pos_r <= pos_r + 6'd1; done_r <= done_r + 32'd1;
        end
      end
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

// ===== rtl/core/cc20_gen.sv =====
module cc20_gen
  import cc20_pkg::*;
#(
  parameter int DOUBLE_ROUNDS = 10
) (
  input  logic         clk,
  input  logic         rst_n,
  input  cc20_req_t    req,
  input  logic [255:0] key,
  input  logic [31:0]  seed,
  input  logic [31:0]  msg_len,
  output logic         done,
  output logic [511:0] block
);
  localparam int RW = $clog2(2 * DOUBLE_ROUNDS + 1);

  gen_state_t    st_r, st_nxt;
  logic [31:0]   init_r [16];
  logic [31:0]   w_r [16];
  logic [31:0]   w_nxt [16];
  logic [RW-1:0] rnd_r;
  logic [31:0]   sw;
  logic [127:0]  q0, q1, q2, q3;

  assign sw = msg_len ^ LEN_MASK;

  // one half round per cycle: column then diagonal
  always_comb begin
    if (!rnd_r[0]) begin
      q0 = qround(w_r[0], w_r[4], w_r[8],  w_r[12]);
      q1 = qround(w_r[1], w_r[5], w_r[9],  w_r[13]);
      q2 = qround(w_r[2], w_r[6], w_r[10], w_r[14]);
      q3 = qround(w_r[3], w_r[7], w_r[11], w_r[15]);
      {w_nxt[12], w_nxt[8],  w_nxt[4], w_nxt[0]} = q0;
      {w_nxt[13], w_nxt[9],  w_nxt[5], w_nxt[1]} = q1;
      {w_nxt[14], w_nxt[10], w_nxt[6], w_nxt[2]} = q2;
      {w_nxt[15], w_nxt[11], w_nxt[7], w_nxt[3]} = q3;
    end else begin
      q0 = qround(w_r[0], w_r[5], w_r[10], w_r[15]);
      q1 = qround(w_r[1], w_r[6], w_r[11], w_r[12]);
      q2 = qround(w_r[2], w_r[7], w_r[8],  w_r[13]);
      q3 = qround(w_r[3], w_r[4], w_r[9],  w_r[14]);
      {w_nxt[15], w_nxt[10], w_nxt[5], w_nxt[0]} = q0;
      {w_nxt[12], w_nxt[11], w_nxt[6], w_nxt[1]} = q1;
      {w_nxt[13], w_nxt[8],  w_nxt[7], w_nxt[2]} = q2;
      {w_nxt[14], w_nxt[9],  w_nxt[4], w_nxt[3]} = q3;
    end
  end

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE:  if (req.start) st_nxt = ST_ROUND;
      ST_ROUND: if (rnd_r == RW'(2 * DOUBLE_ROUNDS - 1)) st_nxt = ST_FINAL;
      ST_FINAL: st_nxt = ST_IDLE;
      default:  st_nxt = ST_IDLE;
    endcase
  end

  assign done = (st_r == ST_FINAL);

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= ST_IDLE;
    else        st_r <= st_nxt;
  end

  // working state and round count
  always_ff @(posedge clk) begin
    if (st_r == ST_IDLE && req.start) begin
      init_r[0] <= SIGMA0; init_r[1] <= SIGMA1;
      init_r[2] <= SIGMA2; init_r[3] <= SIGMA3;
      for (int i = 0; i < 8; i++) init_r[4+i] <= key[32*i +: 32];
      init_r[12] <= req.counter;
      init_r[13] <= seed;
      init_r[14] <= rotl32(seed, 16) ^ sw;
      init_r[15] <= sw;
      w_r[0] <= SIGMA0; w_r[1] <= SIGMA1; w_r[2] <= SIGMA2; w_r[3] <= SIGMA3;
      for (int i = 0; i < 8; i++) w_r[4+i] <= key[32*i +: 32];
      w_r[12] <= req.counter;
      w_r[13] <= seed;
      w_r[14] <= rotl32(seed, 16) ^ sw;
      w_r[15] <= sw;
      rnd_r <= '0;
    end else if (st_r == ST_ROUND) begin
      w_r   <= w_nxt;
      rnd_r <= rnd_r + RW'(1);
    end else if (st_r == ST_FINAL) begin
      for (int i = 0; i < 16; i++) w_r[i] <= w_r[i] + init_r[i];
    end
  end

  // block is valid the cycle after done
  always_comb begin
    for (int i = 0; i < 16; i++) block[32*i +: 32] = w_r[i];
  end
endmodule

// ===== rtl/core/cc20_back.sv =====
module cc20_back
  import cc20_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         q_valid,
  output logic         q_ready,
  input  cc20_item_t   q_item,
  output cc20_req_t    req,
  input  logic         gen_done,
  input  logic [511:0] block,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [7:0]   out_byte,
  output logic         out_last
);
  logic [511:0] ks_r;
  logic [31:0]  ctr_r;
  logic         busy_r, load_r;
  logic         ks_ok_r;
  logic         ov_r;
  logic [7:0]   ob_r;
  logic         ol_r;
  logic         slot_free, need_blk, take;

  assign slot_free = !ov_r || out_ready;
  assign need_blk  = q_valid && q_item.new_block;
  assign take      = q_valid && !busy_r && !load_r && slot_free &&
                     (!q_item.new_block || ks_ok_r);
  assign q_ready   = take;
  assign req.start   = need_blk && !busy_r && !load_r && !ks_ok_r;
  assign req.counter = ctr_r;

  assign out_valid = ov_r;
  assign out_byte  = ob_r;
  assign out_last  = ol_r;

  // keystream buffer refresh and block counter
  always_ff @(posedge clk) begin
    if (load_r) ks_r <= block;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; load_r <= 1'b0; ctr_r <= 32'd0; ov_r <= 1'b0;
      ks_ok_r <= 1'b0;
    end else begin
      load_r <= gen_done;
      if (req.start) begin
        busy_r <= 1'b1;
        ctr_r  <= ctr_r + 32'd1;
      end
      if (load_r) busy_r <= 1'b0;
      // fresh block ready for the waiting block-start byte
      if (load_r) ks_ok_r <= 1'b1;
      else if (take) ks_ok_r <= 1'b0;
      if (take && q_item.last) ctr_r <= 32'd0;
      if (take) ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
    end
  end

  // output register: xor with buffered keystream byte
  always_ff @(posedge clk) begin
    if (take) begin
      ob_r <= q_item.data ^ ks_r[8*q_item.pos +: 8];
      ol_r <= q_item.last;
    end
  end
endmodule

// ===== rtl/core/chacha20_ctr_byte_xor_core.sv =====
// ChaCha20 counter-mode byte cipher. Each accepted item is one message byte,
// returned xored with the next keystream byte; out_tlast marks the final
// byte of a message of message_length bytes, after which counts restart.
// A byte inside a keystream block needs no new keystream block. The first byte of each
// 64-byte block holds the back part through the request, the half rounds of
// the shared round unit, the final add, the buffer load and the byte itself.
// Key, seed and length are sampled when a block starts and should be written
// while the core is idle.
`include "chacha20_ctr_byte_xor_core_defines.svh"
module chacha20_ctr_byte_xor_core
  import cc20_pkg::*;
#(
  parameter int DOUBLE_ROUNDS = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] out_byte
  output logic        out_tlast   // last_byte
);
  logic [255:0] key_r;
  logic [31:0]  seed_r, len_r;
  logic         q_valid, q_ready, gen_done;
  cc20_item_t   q_item;
  cc20_req_t    req;
  logic [511:0] block;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0; seed_r <= '0; len_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_KEY01: key_r[63:0]    <= cfg_data;
        REG_KEY23: key_r[127:64]  <= cfg_data;
        REG_KEY45: key_r[191:128] <= cfg_data;
        REG_KEY67: key_r[255:192] <= cfg_data;
        REG_SEED:  seed_r <= cfg_data[31:0];
        REG_LEN:   len_r  <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  cc20_front u_front (
    .clk, .rst_n, .in_valid(in_tvalid), .in_ready(in_tready), .in_data(in_tdata),
    .msg_len(len_r), .q_valid, .q_ready, .q_item
  );

  cc20_gen #(.DOUBLE_ROUNDS(DOUBLE_ROUNDS)) u_gen (
    .clk, .rst_n, .req, .key(key_r), .seed(seed_r), .msg_len(len_r),
    .done(gen_done), .block
  );

  cc20_back u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_item, .req, .gen_done, .block,
    .out_valid(out_tvalid), .out_ready(out_tready), .out_byte(out_tdata),
    .out_last(out_tlast)
  );

  `CC_ASSERT_NEXT(a_start_busy, req.start, !req.start, "block start repeated")
  `CC_ASSERT_IMP(a_no_take_on_gen, gen_done, !q_ready, "byte taken during keystream load")
  `CC_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid, "result dropped")
endmodule
